// ----- src/bstpm_pkg.sv -----
// Package for the bad-sector tape position map.
// Holds the fixed sizes, the request codes, the beat structs and the memory
// port structs. It depends on nothing else.
package bstpm_pkg;

  localparam int NUM_SEGMENTS        = 4096;
  localparam int SEGMENT_BYTES       = 32768;
  localparam int SECTOR_BYTES        = 1024;
  localparam int SECTORS_PER_SEGMENT = 32;
  localparam int JUMP_DISTANCE       = 10;

  localparam int SEG_W  = $clog2(NUM_SEGMENTS);   // store address
  localparam int CSEG_W = SEG_W + 1;              // segment count up to last+1
  localparam int POS_W  = 28;
  localparam int OFF_W  = 15;
  localparam int MAP_W  = 32;
  localparam int BPOS_W = 32;
  localparam int SIZE_W = $clog2(SEGMENT_BYTES + 1);
  localparam int CFG_W  = 12;

  typedef enum logic [1:0] {
    REQ_LOAD = 2'd0,
    REQ_CAP  = 2'd1,
    REQ_S2P  = 2'd2,
    REQ_P2S  = 2'd3
  } req_e;

  typedef enum logic {
    CFG_FIRST = 1'b0,
    CFG_LAST  = 1'b1
  } cfg_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SETUP,
    S_WALK,
    S_RESP
  } state_e;

  typedef struct packed {
    req_e               req_type;
    logic [CFG_W-1:0]   segment_index;
    logic [MAP_W-1:0]   bad_sector_map;
    logic [BPOS_W-1:0]  byte_position;
  } req_t;

  typedef struct packed {
    logic [12:0]        out_segment;
    logic [OFF_W-1:0]   byte_offset;
    logic [POS_W-1:0]   position_out;
  } res_t;

  typedef struct packed {
    logic               en;
    logic [SEG_W-1:0]   addr;
    logic [MAP_W-1:0]   data;
  } mem_wr_t;

  typedef struct packed {
    logic               en;
    logic [SEG_W-1:0]   addr;
  } mem_rd_t;

endpackage

// ----- src/bstpm_size_store.sv -----
// Bitmap store of the bad-sector tape position map: one bad-sector bitmap
// per segment in a synchronous memory, followed by a registered usable-size
// stage. Depends on bstpm_pkg.
module bstpm_size_store (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  bstpm_pkg::mem_wr_t              wr_i,
  input  bstpm_pkg::mem_rd_t              rd_i,
  input  logic                            flush_i,
  output logic                            size_valid_o,
  output logic [bstpm_pkg::SIZE_W-1:0]    size_o
);
  import bstpm_pkg::*;

  localparam int CNT_W  = $clog2(SECTORS_PER_SEGMENT + 1);
  localparam int PROD_W = $clog2(SECTORS_PER_SEGMENT * SECTOR_BYTES + 1);

  logic [MAP_W-1:0]  mem [NUM_SEGMENTS];
  logic [MAP_W-1:0]  rd_data_q;
  logic              rd_valid_q;
  logic [SIZE_W-1:0] size_q;
  logic              size_valid_q;

  logic [CNT_W-1:0]  bad_cnt;
  logic [PROD_W-1:0] bad_bytes;
  logic [SIZE_W-1:0] size_d;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.en) begin
      rd_data_q <= mem[rd_i.addr];
    end
  end

  // Every sector bit of a bitmap counts.
  always_comb begin
    bad_cnt = '0;
    for (int i = 0; i < SECTORS_PER_SEGMENT; i++) begin
      bad_cnt = bad_cnt + CNT_W'(rd_data_q[i]);
    end
    bad_bytes = PROD_W'(bad_cnt) * PROD_W'(SECTOR_BYTES);
    if (bad_bytes >= PROD_W'(SEGMENT_BYTES)) begin
      size_d = '0;
    end else begin
      size_d = SIZE_W'(PROD_W'(SEGMENT_BYTES) - bad_bytes);
    end
  end

  always_ff @(posedge clk_i) begin
    size_q <= size_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q   <= 1'b0;
      size_valid_q <= 1'b0;
    end else begin
      rd_valid_q   <= rd_i.en & ~flush_i;
      size_valid_q <= rd_valid_q & ~flush_i;
    end
  end

  assign size_valid_o = size_valid_q;
  assign size_o       = size_q;

endmodule

// ----- src/bad_sector_tape_position_map.sv -----
// Top level of the bad-sector tape position map: request sequencer, cached
// walk position, capacity and result registers.
// Depends on bstpm_pkg and bstpm_size_store.
//
//   Channel   Direction  Handshake                   Beat
//   --------  ---------  --------------------------  --------------------------
//   request   in         in_valid_i / in_ready_o     bstpm_pkg::req_t
//   result    out        out_valid_o / out_ready_i   bstpm_pkg::res_t
//   config    in         cfg_we_i (no wait)          cfg_index_i, cfg_data_i
//
// After reset the block sweeps the bitmap store to all zeros, one entry per
// cycle, over all 4096 entries; no request beat is taken during the sweep,
// while configuration writes are taken at any time.
// A load writes its bitmap when its beat is taken, then passes through S_RESP,
// which waits for the output register to be free, back to S_IDLE.
// A capacity request or a translation that walks N segments, one bitmap read
// per cycle, goes through S_SETUP and S_WALK to S_RESP and then frees the
// input; no new request beat is taken before that. A segment-to-position
// request that needs no walk passes from S_SETUP straight to S_RESP.
// The block holds one request at a time; a new request beat is taken while
// the previous result beat still waits on out_ready_i.
module bad_sector_tape_position_map (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  bstpm_pkg::req_t               in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output bstpm_pkg::res_t               out_data_o,
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [bstpm_pkg::CFG_W-1:0]   cfg_data_i
);
  import bstpm_pkg::*;

  localparam int DIFF_W = CSEG_W + 2;
  localparam logic signed [DIFF_W-1:0] JumpLim = DIFF_W'(JUMP_DISTANCE);

  // Control and architectural state.
  state_e             state_q, state_d;
  logic [SEG_W-1:0]   clr_addr_q, clr_addr_d;
  logic [CFG_W-1:0]   first_q, last_q;
  logic [CSEG_W-1:0]  cache_seg_q, cache_seg_d;
  logic [POS_W-1:0]   cache_pos_q, cache_pos_d;
  logic [POS_W-1:0]   cap_q, cap_d;
  logic               out_valid_q, out_valid_d;

  // Request and walk payload.
  req_e               req_q, req_d;
  logic [CFG_W-1:0]   seg_q, seg_d;
  logic [BPOS_W-1:0]  rem_q, rem_d;
  logic               dir_q, dir_d;
  logic [SEG_W-1:0]   iss_addr_q, iss_addr_d;
  logic [CSEG_W-1:0]  iss_left_q, iss_left_d;
  logic [CSEG_W-1:0]  proc_left_q, proc_left_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [CSEG_W-1:0]  wseg_q, wseg_d;
  res_t               res_q, res_d;
  res_t               out_q, out_d;

  mem_wr_t            mem_wr;
  mem_rd_t            mem_rd;
  logic               flush;
  logic               size_valid;
  logic [SIZE_W-1:0]  size;

  // Setup terms.
  logic [CSEG_W-1:0]  first_ext, last_ext, seg_ext, span;
  logic               span_ok, seg_in;
  logic signed [DIFF_W-1:0] nd2, d1, d3, d2a;
  logic               jump_lo, jump_hi, fwd_j;
  logic [CSEG_W-1:0]  cur_j, steps, cur_m1;
  logic [POS_W-1:0]   pos_j;
  logic               setup_walk;

  // Walk terms.
  logic [POS_W-1:0]   pos_step;
  logic               rem_le, rem_lt, walk_done, accept, out_free;

  bstpm_size_store u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_i         (mem_wr),
    .rd_i         (mem_rd),
    .flush_i      (flush),
    .size_valid_o (size_valid),
    .size_o       (size)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i & in_ready_o;
  assign out_free    = ~out_valid_q | out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Where a segment-to-position walk starts. The cached pair is used unless it
  // is more than ten segments from the target and the start or the end of the data area is closer.
  assign first_ext = CSEG_W'(first_q);
  assign last_ext  = CSEG_W'(last_q);
  assign seg_ext   = CSEG_W'(seg_q);
  assign span_ok   = (first_q <= last_q);
  assign span      = last_ext - first_ext + CSEG_W'(1);
  assign seg_in    = (seg_q >= first_q) && (seg_q <= last_q);

  assign nd2 = $signed(DIFF_W'(cache_seg_q)) - $signed(DIFF_W'(seg_q));
  assign d1  = $signed(DIFF_W'(seg_q)) - $signed(DIFF_W'(first_q));
  assign d3  = $signed(DIFF_W'(last_q)) - $signed(DIFF_W'(seg_q));

  assign jump_lo = (nd2 > JumpLim) && (nd2 > d1);
  assign d2a     = jump_lo ? d1 : -nd2;
  assign jump_hi = (d2a > JumpLim) && (d2a > d3);

  assign cur_j  = jump_hi ? last_ext + CSEG_W'(1) : (jump_lo ? first_ext : cache_seg_q);
  assign pos_j  = jump_hi ? cap_q : (jump_lo ? '0 : cache_pos_q);
  assign fwd_j  = (seg_ext > cur_j);
  assign steps  = fwd_j ? seg_ext - cur_j : cur_j - seg_ext;
  assign cur_m1 = cur_j - CSEG_W'(1);

  always_comb begin
    case (req_q)
      REQ_CAP: setup_walk = span_ok;
      REQ_S2P: setup_walk = seg_in && (steps != '0);
      REQ_P2S: setup_walk = (rem_q != '0) && span_ok;
      default: setup_walk = 1'b0;
    endcase
  end

  // Walk arithmetic on the size arriving from the store.
  assign pos_step  = dir_q ? pos_q + POS_W'(size) : pos_q - POS_W'(size);
  assign rem_le    = (rem_q <= BPOS_W'(size));
  assign rem_lt    = (rem_q <  BPOS_W'(size));
  assign walk_done = size_valid &&
                     ((proc_left_q == CSEG_W'(1)) || ((req_q == REQ_P2S) && rem_le));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_addr_q == '1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = (in_data_i.req_type == REQ_LOAD) ? S_RESP : S_SETUP;
        end
      end
      S_SETUP: begin
        state_d = setup_walk ? S_WALK : S_RESP;
      end
      S_WALK: begin
        if (walk_done) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    clr_addr_d  = clr_addr_q;
    cache_seg_d = cache_seg_q;
    cache_pos_d = cache_pos_q;
    cap_d       = cap_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_d       = out_q;
    req_d       = req_q;
    seg_d       = seg_q;
    rem_d       = rem_q;
    dir_d       = dir_q;
    iss_addr_d  = iss_addr_q;
    iss_left_d  = iss_left_q;
    proc_left_d = proc_left_q;
    pos_d       = pos_q;
    wseg_d      = wseg_q;
    res_d       = res_q;
    mem_wr      = '0;
    mem_rd.en   = 1'b0;
    mem_rd.addr = iss_addr_q;
    flush       = 1'b0;

    case (state_q)
      S_CLEAR: begin
        mem_wr.en   = 1'b1;
        mem_wr.addr = clr_addr_q;
        clr_addr_d  = clr_addr_q + SEG_W'(1);
      end

      S_IDLE: begin
        if (accept) begin
          req_d = in_data_i.req_type;
          seg_d = in_data_i.segment_index;
          rem_d = in_data_i.byte_position;
          res_d = '0;
          if (in_data_i.req_type == REQ_LOAD) begin
            mem_wr.en   = 1'b1;
            mem_wr.addr = SEG_W'(in_data_i.segment_index);
            mem_wr.data = in_data_i.bad_sector_map;
          end
        end
      end

      S_SETUP: begin
        case (req_q)
          REQ_CAP: begin
            if (span_ok) begin
              dir_d       = 1'b1;
              iss_addr_d  = SEG_W'(first_q);
              iss_left_d  = span;
              proc_left_d = span;
              pos_d       = '0;
            end else begin
              // Empty data area: capacity zero, cache parked at the first segment.
              cache_seg_d = first_ext;
              cache_pos_d = '0;
              cap_d       = '0;
            end
          end
          REQ_S2P: begin
            if (seg_q > last_q) begin
              res_d.position_out = cap_q;
            end else if (seg_q < first_q) begin
              res_d.position_out = '0;
            end else if (steps == '0) begin
              res_d.position_out = pos_j;
              cache_seg_d        = cur_j;
              cache_pos_d        = pos_j;
            end else begin
              dir_d       = fwd_j;
              iss_addr_d  = fwd_j ? SEG_W'(cur_j) : SEG_W'(cur_m1);
              iss_left_d  = steps;
              proc_left_d = steps;
              pos_d       = pos_j;
            end
          end
          REQ_P2S: begin
            if (setup_walk) begin
              dir_d       = 1'b1;
              iss_addr_d  = SEG_W'(first_q);
              iss_left_d  = span;
              proc_left_d = span;
              wseg_d      = first_ext;
            end else begin
              res_d.out_segment = first_ext;
            end
          end
          default: begin
          end
        endcase
      end

      S_WALK: begin
        // Issue side: one bitmap read per cycle.
        if (iss_left_q != '0) begin
          mem_rd.en  = 1'b1;
          iss_addr_d = dir_q ? iss_addr_q + SEG_W'(1) : iss_addr_q - SEG_W'(1);
          iss_left_d = iss_left_q - CSEG_W'(1);
        end
        // Consume side: sizes come back through the store's read-data and size registers.
        if (size_valid) begin
          proc_left_d = proc_left_q - CSEG_W'(1);
          if (req_q == REQ_P2S) begin
            rem_d  = rem_q - BPOS_W'(size);
            wseg_d = wseg_q + CSEG_W'(1);
            if (rem_le) begin
              res_d.out_segment = rem_lt ? wseg_q : wseg_q + CSEG_W'(1);
              res_d.byte_offset = rem_lt ? OFF_W'(rem_q) : '0;
            end else if (proc_left_q == CSEG_W'(1)) begin
              // Position lies past the last data segment.
              res_d.out_segment = wseg_q + CSEG_W'(1);
              res_d.byte_offset = '0;
            end
          end else begin
            pos_d = pos_step;
            if (proc_left_q == CSEG_W'(1)) begin
              res_d.position_out = pos_step;
              cache_pos_d        = pos_step;
              if (req_q == REQ_CAP) begin
                cap_d       = pos_step;
                cache_seg_d = last_ext + CSEG_W'(1);
              end else begin
                cache_seg_d = seg_ext;
              end
            end
          end
        end
        // Reads still in flight belong to this walk only.
        if (walk_done) begin
          flush = 1'b1;
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end

      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_addr_q  <= '0;
      cache_seg_q <= '0;
      cache_pos_q <= '0;
      cap_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      cache_seg_q <= cache_seg_d;
      cache_pos_q <= cache_pos_d;
      cap_q       <= cap_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Configuration registers; writes leave the cache alone.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= '0;
      last_q  <= '1;
    end else if (cfg_we_i) begin
      case (cfg_e'(cfg_index_i))
        CFG_FIRST: first_q <= cfg_data_i;
        CFG_LAST:  last_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    seg_q       <= seg_d;
    rem_q       <= rem_d;
    dir_q       <= dir_d;
    iss_addr_q  <= iss_addr_d;
    iss_left_q  <= iss_left_d;
    proc_left_q <= proc_left_d;
    pos_q       <= pos_d;
    wseg_q      <= wseg_d;
    res_q       <= res_d;
    out_q       <= out_d;
  end

endmodule
